// File: rtl/core/sskps_pkg.sv
// Package for the stable smallest-k point selector.
// Holds store sizing, the stored point type and the controller/datapath link types.
// No dependencies.
`default_nettype none

package sskps_pkg;

    localparam int KEEP_DEPTH = 64;
    localparam int MAX_OUT    = 64;
    localparam int IDX_W      = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;
    localparam int CNT_W      = $clog2(KEEP_DEPTH + 1);
    localparam int MAXC_W     = 7;
    localparam int OUT_W      = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;
    localparam int PADDR_W    = 3;

    localparam logic [MAXC_W-1:0] MAXC_RESET    = 7'd64;
    localparam logic               REG_MAX_COUNT = 1'b0;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] key;
    } entry_t;

    typedef struct packed {
        logic             in_ready;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic             wr_new;
        logic [IDX_W-1:0] wr_addr;
        logic             load_out;
        logic             out_last;
    } cmd_t;

    typedef struct packed {
        logic in_fire;
        logic pend_last;
        logic key_gt;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/sskps_pt_if.sv
// Input channel interface: one point word per handshake.
// Depends on nothing.
`default_nettype none

interface sskps_pt_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] sigma;
    logic        last_point;

    modport source (output valid, pos_x, pos_y, pos_z, sigma, last_point, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, sigma, last_point, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sskps_res_if.sv
// Output channel interface: one selected point word per handshake.
// Depends on nothing.
`default_nettype none

interface sskps_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [31:0] out_sigma;
    logic        last_result;

    modport source (output valid, out_x, out_y, out_z, out_sigma, last_result, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_sigma, last_result, output ready);
endinterface

`default_nettype wire

// File: rtl/core/stable_smallest_k_point_select.sv
// Stable smallest-k point selector. Points arrive one word at a time and are kept
// in a 64-entry store in ascending sigma order (unsigned compare), equal keys in
// arrival order. Each point is inserted by walking down from the end of the kept
// points, moving each larger key up one place; with a full store, the worst kept
// key is checked first and the point enters only if it beats it. The store is a
// memory with one write and one registered read per cycle, which moves one entry
// per cycle during insertion; no new point is taken until insertion is done.
// After the point marked last, the min(count, max_count, 64) best points go out
// one result word at a time, held by any output stall, and the store is emptied.
// A new point is taken while the last result word waits in the output register.
`default_nettype none

module stable_smallest_k_point_select (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    sskps_pt_if.sink                           points,
    sskps_res_if.source                        results,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sskps_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    logic [sskps_pkg::MAXC_W-1:0] max_count;
    sskps_pkg::cmd_t              cmd;
    sskps_pkg::sts_t              sts;

    sskps_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .max_count (max_count)
    );

    sskps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_count (max_count),
        .sts       (sts),
        .cmd       (cmd)
    );

    sskps_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .points  (points),
        .results (results),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule

`default_nettype wire

// File: rtl/core/sskps_regs.sv
// APB-style configuration register file holding max_count.
// Depends on sskps_pkg.
`default_nettype none

module sskps_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [sskps_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output logic      [sskps_pkg::MAXC_W-1:0] max_count
);

    logic [sskps_pkg::MAXC_W-1:0] max_count_reg;
    logic                         hit;

    assign pready = 1'b1;
    assign hit    = (paddr[2] == sskps_pkg::REG_MAX_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_count_reg <= sskps_pkg::MAXC_RESET;
        end
        else if (psel && penable && pwrite && pready && hit)
        begin
            max_count_reg <= pwdata[sskps_pkg::MAXC_W-1:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (hit)
        begin
            prdata = {{(32 - sskps_pkg::MAXC_W){1'b0}}, max_count_reg};
        end
    end

    assign max_count = max_count_reg;

endmodule

`default_nettype wire

// File: rtl/core/sskps_dp.sv
// Datapath: sorted point store (simple dual-port style memory with registered read),
// pending point register, key compare and output word register. Depends on sskps_pkg.
`default_nettype none

module sskps_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    sskps_pt_if.sink             points,
    sskps_res_if.source          results,
    input  wire sskps_pkg::cmd_t cmd,
    output sskps_pkg::sts_t      sts
);

    sskps_pkg::entry_t kept_mem [sskps_pkg::KEEP_DEPTH];
    sskps_pkg::entry_t rd_data_reg;
    sskps_pkg::entry_t pend_reg;
    logic              pend_last_reg;
    sskps_pkg::entry_t out_reg;
    logic              out_last_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              in_fire;

    assign points.ready = cmd.in_ready;
    assign in_fire      = points.valid && cmd.in_ready;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pend_reg.x    <= points.pos_x;
            pend_reg.y    <= points.pos_y;
            pend_reg.z    <= points.pos_z;
            pend_reg.key  <= points.sigma;
            pend_last_reg <= points.last_point;
        end
    end

    // The store is written and read in the same cycle only at different addresses.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            kept_mem[cmd.wr_addr] <= cmd.wr_new ? pend_reg : rd_data_reg;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= kept_mem[cmd.rd_addr];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg      <= rd_data_reg;
            out_last_reg <= cmd.out_last;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.out_x       = out_reg.x;
    assign results.out_y       = out_reg.y;
    assign results.out_z       = out_reg.z;
    assign results.out_sigma   = out_reg.key;
    assign results.last_result = out_last_reg;

    assign sts.in_fire   = in_fire;
    assign sts.pend_last = pend_last_reg;
    assign sts.key_gt    = rd_data_reg.key > pend_reg.key;
    assign sts.out_free  = !out_valid_reg || results.ready;

endmodule

`default_nettype wire

// File: rtl/core/sskps_ctrl.sv
// Controller: sequences sorted insertion (walk down from the top, moving larger
// keys up one place) and emission of the selected points. Depends on sskps_pkg.
`default_nettype none

module sskps_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [sskps_pkg::MAXC_W-1:0] max_count,
    input  wire sskps_pkg::sts_t              sts,
    output sskps_pkg::cmd_t                   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FULL,
        S_CMP,
        S_PUT,
        S_EM_RD,
        S_EM_LD
    } state_t;

    localparam logic [sskps_pkg::CNT_W-1:0] FULL_CNT =
        sskps_pkg::CNT_W'(sskps_pkg::KEEP_DEPTH);
    localparam logic [sskps_pkg::IDX_W-1:0] TOP_IDX =
        sskps_pkg::IDX_W'(sskps_pkg::KEEP_DEPTH - 1);
    localparam logic [sskps_pkg::OUT_W-1:0] OUT_CAP =
        sskps_pkg::OUT_W'(sskps_pkg::MAX_OUT);

    state_t                       state_reg, state_next;
    logic [sskps_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [sskps_pkg::IDX_W-1:0]  idx_reg, idx_next;
    logic [sskps_pkg::OUT_W-1:0]  emit_reg, emit_next;
    logic [sskps_pkg::OUT_W-1:0]  total_reg, total_next;
    logic [sskps_pkg::OUT_W-1:0]  k_cnt;
    logic [sskps_pkg::OUT_W-1:0]  k_max;
    logic [sskps_pkg::OUT_W-1:0]  k_val;
    logic                         finish;
    logic                         emit_last;

    // Number of results for the cloud: min(count, max_count, output cap).
    always_comb
    begin
        k_cnt = sskps_pkg::OUT_W'(count_reg);
        k_max = sskps_pkg::OUT_W'(max_count);
        k_val = (k_cnt < k_max) ? k_cnt : k_max;
        if (k_val > OUT_CAP)
        begin
            k_val = OUT_CAP;
        end
    end

    assign emit_last = (emit_reg + sskps_pkg::OUT_W'(1)) == total_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        emit_next  = emit_reg;
        total_next = total_reg;
        finish     = 1'b0;

        cmd          = '0;
        cmd.in_ready = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (sts.in_fire)
                begin
                    if (count_reg == FULL_CNT)
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = TOP_IDX;
                        state_next  = S_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + sskps_pkg::CNT_W'(1);
                        idx_next   = count_reg[sskps_pkg::IDX_W-1:0];
                        if (count_reg == '0)
                        begin
                            state_next = S_PUT;
                        end
                        else
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = count_reg[sskps_pkg::IDX_W-1:0]
                                          - sskps_pkg::IDX_W'(1);
                            state_next  = S_CMP;
                        end
                    end
                end
            end

            // Store full: the new point enters only if it beats the worst kept one.
            S_FULL:
            begin
                if (!sts.key_gt)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    idx_next = TOP_IDX;
                    if (TOP_IDX == '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = TOP_IDX - sskps_pkg::IDX_W'(1);
                        state_next  = S_CMP;
                    end
                end
            end

            // Read data holds entry idx-1; a strictly larger key moves up one place.
            S_CMP:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_addr = idx_reg;
                if (sts.key_gt)
                begin
                    cmd.wr_new = 1'b0;
                    idx_next   = idx_reg - sskps_pkg::IDX_W'(1);
                    if (idx_reg == sskps_pkg::IDX_W'(1))
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_addr = idx_reg - sskps_pkg::IDX_W'(2);
                    end
                end
                else
                begin
                    cmd.wr_new = 1'b1;
                    finish     = 1'b1;
                end
            end

            S_PUT:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_new  = 1'b1;
                cmd.wr_addr = idx_reg;
                finish      = 1'b1;
            end

            S_EM_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = emit_reg[sskps_pkg::IDX_W-1:0];
                state_next  = S_EM_LD;
            end

            S_EM_LD:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = emit_last;
                    emit_next    = emit_reg + sskps_pkg::OUT_W'(1);
                    if (emit_last)
                    begin
                        count_next = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EM_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Insertion done: either wait for the next point or start emitting.
        if (finish)
        begin
            state_next = S_IDLE;
            if (sts.pend_last)
            begin
                if (k_val == '0)
                begin
                    count_next = '0;
                end
                else
                begin
                    emit_next  = '0;
                    total_next = k_val;
                    state_next = S_EM_RD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            emit_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            emit_reg  <= emit_next;
            total_reg <= total_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("kept count exceeds store depth");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("output word overwritten before it was taken");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_en && cmd.rd_en && (cmd.wr_addr == cmd.rd_addr)))
        else $error("store read and write at the same address");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && cmd.out_last) |=> (count_reg == '0 && state_reg == S_IDLE))
        else $error("store not emptied after final result");

    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EM_RD || state_reg == S_EM_LD) |-> (emit_reg < total_reg))
        else $error("emission index beyond result count");

endmodule

`default_nettype wire
